// ===== rtl/id3tfe_pkg.sv =====
// ----------------------------------------------------------------------------
// id3tfe_pkg
// Shared types and constants of the ID3 text frame extractor.
// ----------------------------------------------------------------------------
package id3tfe_pkg;

	localparam int unsigned QueueDepthDefault = 4;
	localparam int unsigned NumIds = 6;

	typedef logic [2:0] kind_t;

	localparam kind_t KindYear = 3'd3;

	// Frame identifiers, indexed by frame kind
	localparam logic [31:0] FrameIds [NumIds] = '{
		32'h54495432, // TIT2
		32'h54504531, // TPE1
		32'h54414C42, // TALB
		32'h54594552, // TYER
		32'h434F4D4D, // COMM
		32'h54434F4E  // TCON
	};

	localparam logic [7:0] PrintLo = 8'h20;
	localparam logic [7:0] PrintHi = 8'h7E;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ===== rtl/id3tfe_byte_if.sv =====
// ----------------------------------------------------------------------------
// id3tfe_byte_if
// Request channel carrying one raw file byte.
// ----------------------------------------------------------------------------
interface id3tfe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/id3tfe_frame_if.sv =====
// ----------------------------------------------------------------------------
// id3tfe_frame_if
// Request channel carrying one extracted frame payload byte.
// ----------------------------------------------------------------------------
interface id3tfe_frame_if;
	logic       valid;
	logic       ready;
	logic [2:0] tag_kind;
	logic [7:0] payload_byte;
	logic       printable;
	logic       frame_last;

	modport source (output valid, output tag_kind, output payload_byte,
		output printable, output frame_last, input ready);
	modport sink (input valid, input tag_kind, input payload_byte,
		input printable, input frame_last, output ready);
endinterface

// ===== rtl/id3tfe_front.sv =====
// ----------------------------------------------------------------------------
// id3tfe_front
// Byte parser: header skip, identifier search, size and flag fields, and
// tagging of payload bytes pushed into the queue.
// ----------------------------------------------------------------------------
module id3tfe_front import id3tfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	id3tfe_byte_if.sink       file_data,
	input  qstat_t            q_stat,
	output push_t             push
);

	typedef enum logic [2:0] {
		PhHeader,
		PhSearch,
		PhSize,
		PhFlags,
		PhPayload,
		PhDone
	} phase_t;

	phase_t      phase_q;
	logic [23:0] recent_q;
	logic [1:0]  hdr_cnt_q;
	logic [1:0]  cnt_q;
	logic [31:0] remain_q;
	kind_t       kind_q;

	logic        accept;
	logic [7:0]  b;
	logic [31:0] word;
	logic        hit;
	kind_t       hit_kind;

	assign file_data.ready = !q_stat.full;
	assign accept = file_data.valid && file_data.ready;
	assign b = file_data.data_byte;
	assign word = {recent_q, b};

	always_comb begin
		hit = 1'b0;
		hit_kind = '0;
		for (int unsigned k = 0; k < NumIds; k++) begin
			if (!hit && word == FrameIds[k]) begin
				hit = 1'b1;
				hit_kind = kind_t'(k);
			end
		end
	end

	assign push.valid = accept && (phase_q == PhPayload);
	assign push.entry.kind = kind_q;
	assign push.entry.data = b;
	assign push.entry.last = (remain_q == 32'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhHeader;
			recent_q <= '0;
			hdr_cnt_q <= '0;
			cnt_q <= '0;
			remain_q <= '0;
			kind_q <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PhHeader: begin
					if (hdr_cnt_q == 2'd2) begin
						hdr_cnt_q <= '0;
						phase_q <= PhSearch;
					end else begin
						hdr_cnt_q <= hdr_cnt_q + 2'd1;
					end
				end
				PhSearch: begin
					if (hit) begin
						// clear the window so no frame byte joins a later match
						kind_q <= hit_kind;
						recent_q <= '0;
						cnt_q <= '0;
						remain_q <= '0;
						phase_q <= PhSize;
					end else begin
						recent_q <= word[23:0];
					end
				end
				PhSize: begin
					remain_q <= {remain_q[23:0], b};
					if (cnt_q == 2'd3) begin
						cnt_q <= '0;
						phase_q <= PhFlags;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				PhFlags: begin
					if (cnt_q == 2'd0) begin
						cnt_q <= 2'd1;
					end else begin
						cnt_q <= '0;
						if (remain_q == '0) begin
							recent_q <= '0;
							phase_q <= (kind_q == KindYear) ? PhDone : PhSearch;
						end else begin
							phase_q <= PhPayload;
						end
					end
				end
				PhPayload: begin
					remain_q <= remain_q - 32'd1;
					if (remain_q == 32'd1) begin
						recent_q <= '0;
						phase_q <= (kind_q == KindYear) ? PhDone : PhSearch;
					end
				end
				PhDone: begin
					// drop everything until reset
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/id3tfe_queue.sv =====
// ----------------------------------------------------------------------------
// id3tfe_queue
// Short FIFO of tagged payload bytes between the parser and the output stage.
// ----------------------------------------------------------------------------
module id3tfe_queue import id3tfe_pkg::*; #(
	parameter int unsigned Depth = QueueDepthDefault
) (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output qstat_t stat,
	output entry_t head
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

	entry_t          mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign stat.full = (count_q == CntW'(Depth));
	assign stat.empty = (count_q == '0);
	assign do_push = push.valid && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/id3tfe_back.sv =====
// ----------------------------------------------------------------------------
// id3tfe_back
// Output stage: takes queued payload bytes, marks printable ones, and holds
// each request until the consumer takes it.
// ----------------------------------------------------------------------------
module id3tfe_back import id3tfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  qstat_t            q_stat,
	input  entry_t            head,
	output logic              pop,
	id3tfe_frame_if.source    tag_data
);

	logic       valid_q;
	kind_t      kind_q;
	logic [7:0] byte_q;
	logic       print_q;
	logic       last_q;

	// advance when the register is empty or its request is being taken
	assign pop = !q_stat.empty && (!valid_q || tag_data.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || tag_data.ready) begin
			valid_q <= !q_stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head.kind;
			byte_q <= head.data;
			print_q <= (head.data >= PrintLo) && (head.data <= PrintHi);
			last_q <= head.last;
		end
	end

	assign tag_data.valid = valid_q;
	assign tag_data.tag_kind = kind_q;
	assign tag_data.payload_byte = byte_q;
	assign tag_data.printable = print_q;
	assign tag_data.frame_last = last_q;

endmodule

// ===== rtl/id3_text_frame_extractor_top.sv =====
// ----------------------------------------------------------------------------
// id3_text_frame_extractor_top
// ID3 text frame extractor: parses a raw tag byte stream and emits the
// payload bytes of the title, artist, album, year, comment and genre frames.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue is not full.
// An accepted payload byte is written into the queue and then loaded into
// the output register, which offers it on tag_data.
// The parser stalls only when the queue is full (QueueDepth entries).
// Reset (arst_n low) returns the parser to header skip, empties the queue and
// drops any pending output request.
// ----------------------------------------------------------------------------
module id3_text_frame_extractor_top import id3tfe_pkg::*; #(
	parameter int unsigned QueueDepth = QueueDepthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	id3tfe_byte_if.sink       file_data,
	id3tfe_frame_if.source    tag_data
);

	push_t  q_push;
	qstat_t q_stat;
	entry_t q_head;
	logic   q_pop;

	id3tfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.file_data (file_data),
		.q_stat    (q_stat),
		.push      (q_push)
	);

	id3tfe_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.pop    (q_pop),
		.stat   (q_stat),
		.head   (q_head)
	);

	id3tfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head     (q_head),
		.pop      (q_pop),
		.tag_data (tag_data)
	);

	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.valid |-> (file_data.valid && file_data.ready))
		else $error("queue write without an accepted byte");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.valid |-> !q_stat.full)
		else $error("queue write while full");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue read while empty");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_data.valid && !tag_data.ready) |-> !q_pop)
		else $error("pending output overwritten");

endmodule

// ===== bench/id3tfe_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// id3tfe_frame_checker
// Watches both channels of the ID3 text frame extractor, tracks the tag parse
// on every accepted file byte and compares each accepted payload byte with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module id3tfe_frame_checker import id3tfe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	id3tfe_byte_if  file_mon,
	id3tfe_frame_if tag_mon,
	output int      fail_count,
	output int      pending
);

	typedef enum logic [2:0] {
		PhHeader,
		PhSearch,
		PhSize,
		PhFlags,
		PhPayload,
		PhDone
	} parse_phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       printable;
		logic       last;
	} tag_byte_t;

	tag_byte_t    expected_bytes [$];
	logic [23:0]  window = '0;
	parse_phase_t phase = PhHeader;
	logic [1:0]   hdr_cnt = '0;
	logic [1:0]   size_cnt = '0;
	logic [31:0]  remaining = '0;
	kind_t        kind = '0;
	int           errors = 0;

	task finish_frame();
		window = '0;
		phase = (kind == KindYear) ? PhDone : PhSearch;
	endtask

	task parse_byte(input logic [7:0] b);
		logic [31:0] word;
		bit          hit;
		tag_byte_t   t;
		case (phase)
			PhHeader: begin
				hdr_cnt = hdr_cnt + 2'd1;
				if (hdr_cnt == 2'd3) begin
					hdr_cnt = '0;
					phase = PhSearch;
				end
			end
			PhSearch: begin
				word = {window, b};
				hit = 1'b0;
				for (int k = 0; k < NumIds; k++) begin
					if (!hit && word == FrameIds[k]) begin
						hit = 1'b1;
						kind = kind_t'(k);
					end
				end
				if (hit) begin
					// clear the window so no earlier byte joins a later match
					window = '0;
					size_cnt = '0;
					remaining = '0;
					phase = PhSize;
				end else begin
					window = word[23:0];
				end
			end
			PhSize: begin
				remaining = {remaining[23:0], b};
				if (size_cnt == 2'd3) begin
					size_cnt = '0;
					phase = PhFlags;
				end else begin
					size_cnt = size_cnt + 2'd1;
				end
			end
			PhFlags: begin
				if (size_cnt == 2'd0) begin
					size_cnt = 2'd1;
				end else begin
					size_cnt = '0;
					if (remaining == '0)
						finish_frame();
					else
						phase = PhPayload;
				end
			end
			PhPayload: begin
				t.kind = kind;
				t.data = b;
				t.printable = (b >= PrintLo && b <= PrintHi);
				t.last = (remaining == 32'd1);
				expected_bytes.push_back(t);
				remaining = remaining - 32'd1;
				if (remaining == '0)
					finish_frame();
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		tag_byte_t want;
		if (!arst_n) begin
			expected_bytes.delete();
			window = '0;
			phase = PhHeader;
			hdr_cnt = '0;
			size_cnt = '0;
			remaining = '0;
			kind = '0;
			pending <= 0;
			fail_count <= errors;
		end else begin
			if (file_mon.valid && file_mon.ready)
				parse_byte(file_mon.data_byte);
			if (tag_mon.valid && tag_mon.ready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected payload byte: kind %0d data %02h",
						tag_mon.tag_kind, tag_mon.payload_byte);
					errors++;
				end else begin
					want = expected_bytes.pop_front();
					if (tag_mon.tag_kind !== want.kind) begin
						$error("tag_kind: expected %0d, got %0d", want.kind, tag_mon.tag_kind);
						errors++;
					end
					if (tag_mon.payload_byte !== want.data) begin
						$error("payload_byte: expected %02h, got %02h",
							want.data, tag_mon.payload_byte);
						errors++;
					end
					if (tag_mon.printable !== want.printable) begin
						$error("printable: expected %0b, got %0b",
							want.printable, tag_mon.printable);
						errors++;
					end
					if (tag_mon.frame_last !== want.last) begin
						$error("frame_last: expected %0b, got %0b", want.last, tag_mon.frame_last);
						errors++;
					end
				end
			end
			pending <= expected_bytes.size();
			fail_count <= errors;
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the ID3 text frame extractor one tag stream: a short directed opening,
// then random frames mixed with noise and broken identifiers, closed by a year
// frame and some bytes that must be ignored. Both sides stall at random; the
// checker beside the block predicts and compares every payload byte.
// ----------------------------------------------------------------------------
module testbench import id3tfe_pkg::*; ();

	localparam kind_t KindTitle = 3'd0;
	localparam kind_t KindArtist = 3'd1;
	localparam kind_t KindAlbum = 3'd2;
	localparam kind_t KindComment = 3'd4;
	localparam kind_t KindGenre = 3'd5;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;

	logic [7:0] file_stream [$];

	id3tfe_byte_if  file_ch ();
	id3tfe_frame_if tag_ch ();

	id3_text_frame_extractor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.file_data (file_ch),
		.tag_data  (tag_ch)
	);

	id3tfe_frame_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.file_mon   (file_ch),
		.tag_mon    (tag_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #4 clk = ~clk;

	// identifier, big-endian size and two flag bytes of one frame
	task add_frame_head(input kind_t k, input logic [31:0] len);
		for (int i = 3; i >= 0; i--)
			file_stream.push_back(FrameIds[k][8*i +: 8]);
		for (int i = 3; i >= 0; i--)
			file_stream.push_back(len[8*i +: 8]);
		repeat (2) file_stream.push_back(8'($urandom_range(0, 255)));
	endtask

	task build_stream();
		int          pick;
		int          sel;
		int          n;
		kind_t       k;
		logic [31:0] len;
		// header, then an overlapping identifier, a zero-size frame and a
		// payload ending in a partial year identifier completed right after
		file_stream.push_back(8'hFF);
		file_stream.push_back(8'h00);
		file_stream.push_back(8'h49);
		file_stream.push_back(8'h54);
		add_frame_head(KindArtist, 32'd0);
		add_frame_head(KindTitle, 32'd4);
		file_stream.push_back(8'hFF);
		file_stream.push_back(8'h54);
		file_stream.push_back(8'h59);
		file_stream.push_back(8'h45);
		file_stream.push_back(8'h52);
		while (file_stream.size() < 1840) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				case ($urandom_range(0, 4))
					0: k = KindTitle;
					1: k = KindArtist;
					2: k = KindAlbum;
					3: k = KindComment;
					default: k = KindGenre;
				endcase
				sel = $urandom_range(0, 99);
				if (sel < 80)
					len = $urandom_range(0, 6);
				else if (sel < 97)
					len = $urandom_range(7, 24);
				else
					len = 32'h100 + $urandom_range(0, 8);
				add_frame_head(k, len);
				repeat (len) file_stream.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 4)) file_stream.push_back(8'($urandom_range(0, 255)));
			end else begin
				// broken identifier: a prefix cut by a byte that continues none
				k = kind_t'($urandom_range(0, NumIds - 1));
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					file_stream.push_back(FrameIds[k][8*(3-i) +: 8]);
				file_stream.push_back(8'($urandom_range(0, 8'h2F)));
			end
		end
		len = $urandom_range(1, 6);
		add_frame_head(KindYear, len);
		repeat (len) file_stream.push_back(8'($urandom_range(0, 255)));
		// parse is over: this frame must be dropped
		add_frame_head(KindTitle, 32'd2);
		repeat (2) file_stream.push_back(8'($urandom_range(0, 255)));
	endtask

	initial begin
		int  gap;
		bit  burst;
		file_ch.valid <= 1'b0;
		file_ch.data_byte <= '0;
		build_stream();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		burst = 1'b0;
		foreach (file_stream[i]) begin
			if (i % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			gap = burst ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				file_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			file_ch.valid <= 1'b1;
			file_ch.data_byte <= file_stream[i];
			@(posedge clk);
			while (!file_ch.ready) @(posedge clk);
		end
		file_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		int gap;
		bit burst;
		int n;
		tag_ch.ready <= 1'b0;
		@(posedge arst_n);
		n = 0;
		burst = 1'b0;
		forever begin
			if (n % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			n++;
			gap = burst ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				tag_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tag_ch.ready <= 1'b1;
			@(posedge clk);
			while (!tag_ch.valid) @(posedge clk);
		end
	end

	initial begin
		#4ms;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/id3tfe_pkg.sv
rtl/id3tfe_byte_if.sv
rtl/id3tfe_frame_if.sv
rtl/id3tfe_front.sv
rtl/id3tfe_queue.sv
rtl/id3tfe_back.sv
rtl/id3_text_frame_extractor_top.sv
bench/id3tfe_frame_checker.sv
bench/testbench.sv
